FILE: sv/xalu_pkg.sv
`default_nettype none
package xalu_pkg;

   localparam int DataWidth = 32;
   localparam int QueueDepth = 2;

   localparam logic [3:0] OP_ADD   = 4'd0;
   localparam logic [3:0] OP_SUB   = 4'd1;
   localparam logic [3:0] OP_CMP   = 4'd2;
   localparam logic [3:0] OP_INC   = 4'd3;
   localparam logic [3:0] OP_DEC   = 4'd4;
   localparam logic [3:0] OP_NEG   = 4'd5;
   localparam logic [3:0] OP_ADC   = 4'd6;
   localparam logic [3:0] OP_SBB   = 4'd7;
   localparam logic [3:0] OP_MUL   = 4'd8;
   localparam logic [3:0] OP_IMUL1 = 4'd9;
   localparam logic [3:0] OP_IMUL2 = 4'd10;
   localparam logic [3:0] OP_IMUL3 = 4'd11;
   localparam logic [3:0] OP_DIV   = 4'd12;
   localparam logic [3:0] OP_IDIV  = 4'd13;

   localparam logic [1:0] W8  = 2'd0;
   localparam logic [1:0] W16 = 2'd1;
   localparam logic [1:0] W32 = 2'd2;

   localparam logic [1:0] ACC_NONE  = 2'd0;
   localparam logic [1:0] ACC_AX    = 2'd1;
   localparam logic [1:0] ACC_AXDX  = 2'd2;
   localparam logic [1:0] ACC_EAXDX = 2'd3;

   localparam logic [1:0] CLS_ALU = 2'd0;
   localparam logic [1:0] CLS_MUL = 2'd1;
   localparam logic [1:0] CLS_DIV = 2'd2;
   localparam logic [1:0] CLS_NOP = 2'd3;

   // classified word passed from front to back
   typedef struct packed {
      logic [3:0]  opcode;
      logic [1:0]  cls;
      logic [1:0]  wcode;
      logic [31:0] mask;
      logic [31:0] sign;
      logic [31:0] dval;
      logic [31:0] sval;
      logic [31:0] s2val;
      logic [31:0] mul_a;
      logic [31:0] mul_b;
      logic [63:0] dividend;
   } item_type;

   typedef struct packed {
      logic [31:0] result;
      logic        write_dest;
      logic [31:0] acc_low;
      logic [31:0] acc_high;
      logic [1:0]  acc_write_mode;
      logic        carry_flag;
      logic        overflow_flag;
      logic        zero_flag;
      logic        sign_flag;
      logic        divide_error;
   } rsp_type;

   function automatic logic [1:0] width_code(input logic [2:0] w);
      logic [1:0] c;
      c = (w == 3'd1) ? W8 : (w == 3'd2) ? W16 : W32;
      return c;
   endfunction

   function automatic logic [31:0] mask_of(input logic [1:0] c);
      logic [31:0] m;
      m = (c == W8) ? 32'h0000_00ff : (c == W16) ? 32'h0000_ffff : 32'hffff_ffff;
      return m;
   endfunction

   function automatic logic [31:0] sext32(input logic [31:0] v, input logic [1:0] c);
      logic [31:0] r;
      r = (c == W8) ? {{24{v[7]}}, v[7:0]} :
          (c == W16) ? {{16{v[15]}}, v[15:0]} : v;
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: sv/xalu_front.sv
`default_nettype none
module xalu_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [3:0]          opcode,
   input  wire logic [2:0]          operand_width,
   input  wire logic [2:0]          source_width,
   input  wire logic [31:0]         dest_value,
   input  wire logic [31:0]         src_value,
   input  wire logic [31:0]         src2_value,
   input  wire logic [31:0]         eax_value,
   input  wire logic [31:0]         edx_value,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output xalu_pkg::item_type       out_item
);

   xalu_pkg::item_type it;
   logic [1:0] wc;
   logic [1:0] sc;
   logic [31:0] m;

   always_comb begin
      wc = xalu_pkg::width_code(operand_width);
      sc = xalu_pkg::width_code(source_width);
      m  = xalu_pkg::mask_of(wc);
      it = '0;
      it.opcode = opcode;
      it.wcode  = wc;
      it.mask   = m;
      it.sign   = (wc == xalu_pkg::W8) ? 32'h80 : (wc == xalu_pkg::W16) ? 32'h8000 :
                  32'h8000_0000;
      it.dval   = dest_value & m;
      it.sval   = src_value & m;
      it.s2val  = src2_value;
      unique case (opcode)
         xalu_pkg::OP_ADD, xalu_pkg::OP_SUB, xalu_pkg::OP_CMP, xalu_pkg::OP_INC,
         xalu_pkg::OP_DEC, xalu_pkg::OP_NEG, xalu_pkg::OP_ADC, xalu_pkg::OP_SBB:
            it.cls = xalu_pkg::CLS_ALU;
         xalu_pkg::OP_MUL: begin
            it.cls = xalu_pkg::CLS_MUL;
            it.mul_a = dest_value & m;
            it.mul_b = eax_value & m;
         end
         xalu_pkg::OP_IMUL1: begin
            it.cls = xalu_pkg::CLS_MUL;
            it.mul_a = xalu_pkg::sext32(dest_value, wc);
            it.mul_b = xalu_pkg::sext32(eax_value, wc);
         end
         xalu_pkg::OP_IMUL2: begin
            it.cls = xalu_pkg::CLS_MUL;
            it.mul_a = xalu_pkg::sext32(dest_value, wc);
            it.mul_b = xalu_pkg::sext32(src_value, sc);
         end
         xalu_pkg::OP_IMUL3: begin
            it.cls = xalu_pkg::CLS_MUL;
            it.mul_a = xalu_pkg::sext32(src_value, sc);
            it.mul_b = xalu_pkg::sext32(src2_value, sc);
         end
         xalu_pkg::OP_DIV, xalu_pkg::OP_IDIV: begin
            it.cls = xalu_pkg::CLS_DIV;
            it.dividend = (wc == xalu_pkg::W8) ? {48'd0, eax_value[15:0]} :
                          (wc == xalu_pkg::W16) ? {32'd0, edx_value[15:0], eax_value[15:0]} :
                          {edx_value, eax_value};
         end
         default: it.cls = xalu_pkg::CLS_NOP;
      endcase
   end

   // two-entry queue
   xalu_pkg::item_type q_ff [xalu_pkg::QueueDepth];
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = (cnt_ff != 2'(xalu_pkg::QueueDepth));
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = q_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      rd_in  = pop ? ~rd_ff : rd_ff;
      wr_in  = push ? ~wr_ff : wr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= it;
      end
   end

endmodule
`default_nettype wire

FILE: sv/xalu_back.sv
`default_nettype none
module xalu_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire xalu_pkg::item_type  in_item,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output xalu_pkg::rsp_type        out_rsp,
   output logic                     busy
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0] st_ff, st_in;
   xalu_pkg::item_type it_ff;
   logic cf_ff, of_ff, zf_ff, sf_ff;
   logic cf_in, of_in, zf_in, sf_in;
   logic ov_ff, ov_in;
   xalu_pkg::rsp_type rsp_ff, rsp_in;
   logic [63:0] prod_ff;
   // divider: magnitudes, remainder and quotient shift register
   logic [63:0] num_ff, num_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dm_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic nsg_ff, dsg_ff;

   logic take;
   logic [32:0] sum;
   logic [31:0] r32, d, s, c32;
   logic [32:0] dif;
   logic [63:0] nmag;
   logic [31:0] dmag;
   logic nsg, dsg;
   logic [6:0] nbits;
   logic [33:0] trial;
   logic [31:0] qm, rm, q, r, lim;
   logic neg;
   // extra top bit sign-extends the operands of the signed multiplies
   logic xa, xb;
   logic signed [65:0] prod_s;

   assign take     = in_valid && in_ready;
   assign in_ready = (st_ff == ST_IDLE) && !ov_ff;
   assign out_valid = ov_ff;
   assign out_rsp  = rsp_ff;
   assign busy     = (st_ff != ST_IDLE) || ov_ff;

   always_comb begin
      d = in_item.dval;
      s = in_item.sval;
      nsg = (in_item.wcode == xalu_pkg::W8) ? in_item.dividend[15] :
            (in_item.wcode == xalu_pkg::W16) ? in_item.dividend[31] : in_item.dividend[63];
      dsg = (d & in_item.sign) != 32'd0;
      nmag = in_item.dividend;
      if (nsg && in_item.opcode == xalu_pkg::OP_IDIV) begin
         nmag = (64'd0 - in_item.dividend) &
                ((in_item.wcode == xalu_pkg::W8) ? 64'hffff :
                 (in_item.wcode == xalu_pkg::W16) ? 64'hffff_ffff : '1);
      end
      dmag = (dsg && in_item.opcode == xalu_pkg::OP_IDIV) ? ((32'd0 - d) & in_item.mask) : d;
      nbits = (in_item.wcode == xalu_pkg::W8) ? 7'd16 :
              (in_item.wcode == xalu_pkg::W16) ? 7'd32 : 7'd64;
      xa = (in_item.opcode != xalu_pkg::OP_MUL) && in_item.mul_a[31];
      xb = (in_item.opcode != xalu_pkg::OP_MUL) && in_item.mul_b[31];
      prod_s = $signed({xa, in_item.mul_a}) * $signed({xb, in_item.mul_b});
   end

   always_comb begin
      st_in = st_ff;
      cf_in = cf_ff; of_in = of_ff; zf_in = zf_ff; sf_in = sf_ff;
      ov_in = ov_ff && !out_ready;
      rsp_in = rsp_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      c32 = {31'd0, cf_ff};
      sum = '0; dif = '0; r32 = '0;
      trial = '0; qm = '0; rm = '0; q = '0; r = '0; lim = '0; neg = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (take) begin
               rsp_in = '0;
               unique case (in_item.cls)
                  xalu_pkg::CLS_ALU: begin
                     unique case (in_item.opcode)
                        xalu_pkg::OP_ADD, xalu_pkg::OP_ADC: begin
                           sum = {1'b0, d} + {1'b0, s} +
                                 ((in_item.opcode == xalu_pkg::OP_ADC) ? {1'b0, c32} : 33'd0);
                           r32 = sum[31:0] & in_item.mask;
                           cf_in = (sum > {1'b0, in_item.mask});
                           of_in = ((~(d ^ s)) & (d ^ r32) & in_item.sign) != 32'd0;
                        end
                        xalu_pkg::OP_SUB, xalu_pkg::OP_CMP, xalu_pkg::OP_SBB: begin
                           dif = {1'b0, s} +
                                 ((in_item.opcode == xalu_pkg::OP_SBB) ? {1'b0, c32} : 33'd0);
                           cf_in = {1'b0, d} < dif;
                           r32 = (d - dif[31:0]) & in_item.mask;
                           of_in = ((d ^ s) & (d ^ r32) & in_item.sign) != 32'd0;
                        end
                        xalu_pkg::OP_INC: begin
                           r32 = (d + 32'd1) & in_item.mask;
                           of_in = (r32 == in_item.sign);
                        end
                        xalu_pkg::OP_DEC: begin
                           r32 = (d - 32'd1) & in_item.mask;
                           of_in = (d == in_item.sign);
                        end
                        default: begin
                           r32 = (32'd0 - d) & in_item.mask;
                           of_in = (d == in_item.sign);
                           cf_in = (d != 32'd0);
                        end
                     endcase
                     zf_in = (r32 == 32'd0);
                     sf_in = (r32 & in_item.sign) != 32'd0;
                     if (in_item.opcode != xalu_pkg::OP_CMP) begin
                        rsp_in.result = r32;
                        rsp_in.write_dest = 1'b1;
                     end
                     st_in = ST_FIN;
                  end
                  xalu_pkg::CLS_MUL: st_in = ST_MUL;
                  xalu_pkg::CLS_DIV: begin
                     if (dmag == 32'd0) begin
                        rsp_in.divide_error = 1'b1;
                        st_in = ST_FIN;
                     end else begin
                        num_in = nmag << (7'd64 - nbits);
                        rem_in = '0;
                        cnt_in = nbits;
                        st_in = ST_DIV;
                     end
                  end
                  default: st_in = ST_FIN;
               endcase
            end
         end
         ST_MUL: begin
            if (it_ff.opcode == xalu_pkg::OP_IMUL2 || it_ff.opcode == xalu_pkg::OP_IMUL3) begin
               rsp_in.result = prod_ff[31:0] & it_ff.mask;
               rsp_in.write_dest = 1'b1;
            end else if (it_ff.wcode == xalu_pkg::W8) begin
               rsp_in.acc_low = {16'd0, prod_ff[15:0]};
               rsp_in.acc_write_mode = xalu_pkg::ACC_AX;
            end else if (it_ff.wcode == xalu_pkg::W16) begin
               rsp_in.acc_low = {16'd0, prod_ff[15:0]};
               rsp_in.acc_high = {16'd0, prod_ff[31:16]};
               rsp_in.acc_write_mode = xalu_pkg::ACC_AXDX;
            end else begin
               rsp_in.acc_low = prod_ff[31:0];
               rsp_in.acc_high = prod_ff[63:32];
               rsp_in.acc_write_mode = xalu_pkg::ACC_EAXDX;
            end
            st_in = ST_FIN;
         end
         ST_DIV: begin
            // restoring step, one quotient bit a cycle; quotient shifts into num
            trial = {rem_ff, num_ff[63]} - {2'b0, dm_ff};
            if (!trial[33]) begin
               rem_in = trial[32:0];
               num_in = {num_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[31:0], num_ff[63]};
               num_in = {num_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               st_in = ST_FIN;
               rsp_in = '0;
               neg = nsg_ff ^ dsg_ff;
               // quotient needs more than 32 bits only in the 64-bit case: check top bits
               qm = num_in[31:0];
               rm = rem_in[31:0];
               if (it_ff.opcode == xalu_pkg::OP_DIV) begin
                  lim = it_ff.mask;
               end else begin
                  lim = neg ? it_ff.sign : it_ff.sign - 32'd1;
               end
               if ((it_ff.wcode == xalu_pkg::W32 && num_in[63:32] != 32'd0) || qm > lim) begin
                  rsp_in.divide_error = 1'b1;
               end else begin
                  q = ((it_ff.opcode == xalu_pkg::OP_IDIV && neg) ? 32'd0 - qm : qm) &
                      it_ff.mask;
                  r = ((it_ff.opcode == xalu_pkg::OP_IDIV && nsg_ff) ? 32'd0 - rm : rm) &
                      it_ff.mask;
                  if (it_ff.wcode == xalu_pkg::W8) begin
                     rsp_in.acc_low = {16'd0, r[7:0], q[7:0]};
                     rsp_in.acc_write_mode = xalu_pkg::ACC_AX;
                  end else begin
                     rsp_in.acc_low = q;
                     rsp_in.acc_high = r;
                     rsp_in.acc_write_mode = (it_ff.wcode == xalu_pkg::W16) ?
                                             xalu_pkg::ACC_AXDX : xalu_pkg::ACC_EAXDX;
                  end
               end
            end
         end
         default: begin
            rsp_in.carry_flag = cf_ff;
            rsp_in.overflow_flag = of_ff;
            rsp_in.zero_flag = zf_ff;
            rsp_in.sign_flag = sf_ff;
            ov_in = 1'b1;
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
         cf_ff <= 1'b0;
         of_ff <= 1'b0;
         zf_ff <= 1'b0;
         sf_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
         cf_ff <= cf_in;
         of_ff <= of_in;
         zf_ff <= zf_in;
         sf_ff <= sf_in;
      end
      rsp_ff <= rsp_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (take) begin
         it_ff  <= in_item;
         prod_ff <= prod_s[63:0];
         dm_ff  <= dmag;
         nsg_ff <= nsg && (in_item.opcode == xalu_pkg::OP_IDIV);
         dsg_ff <= dsg && (in_item.opcode == xalu_pkg::OP_IDIV);
      end
   end

endmodule
`default_nettype wire

FILE: sv/x86_integer_alu_flags_core.sv
`default_nettype none
// x86 integer arithmetic unit keeping CF, OF, ZF and SF. A front end masks and
// classifies each request word and places it in a two-entry queue; the back end
// executes one word at a time and returns one response word, held in an output
// register. add, sub, cmp, inc, dec, neg, adc and sbb go from idle to the finish
// state; multiplies pass through a multiply state (one registered 33x33 signed
// product); div/idiv run the restoring one-bit-a-cycle divider for one step per
// dividend bit (16, 32 or 64). A zero divisor goes from idle straight to finish.
module x86_integer_alu_flags_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // opcode[3:0], operand_width[6:4], source_width[9:7], dest_value[41:10],
   // src_value[73:42], src2_value[105:74], eax_value[137:106], edx_value[169:138]
   input  wire logic [175:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // result[31:0], write_dest[32], acc_low[64:33], acc_high[96:65],
   // acc_write_mode[98:97], carry_flag[99], overflow_flag[100], zero_flag[101],
   // sign_flag[102], divide_error[103]
   output logic [103:0]       rsp_tdata
);

   logic q_valid, q_ready, busy;
   xalu_pkg::item_type q_item;
   xalu_pkg::rsp_type rsp;

   xalu_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .opcode(req_tdata[3:0]), .operand_width(req_tdata[6:4]),
      .source_width(req_tdata[9:7]), .dest_value(req_tdata[41:10]),
      .src_value(req_tdata[73:42]), .src2_value(req_tdata[105:74]),
      .eax_value(req_tdata[137:106]), .edx_value(req_tdata[169:138]),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   xalu_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rsp(rsp), .busy(busy)
   );

   assign rsp_tdata = {rsp.divide_error, rsp.sign_flag, rsp.zero_flag, rsp.overflow_flag,
                       rsp.carry_flag, rsp.acc_write_mode, rsp.acc_high, rsp.acc_low,
                       rsp.write_dest, rsp.result};

   a_err_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.divide_error |->
         !rsp.write_dest && rsp.acc_write_mode == xalu_pkg::ACC_NONE)
      else $error("divide fault with a write");
   a_dest_no_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.write_dest |-> rsp.acc_write_mode == xalu_pkg::ACC_NONE)
      else $error("both destination and accumulator written");
   a_idle_on_rsp: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_ready |-> !rsp_tvalid)
      else $error("back end took a word while a response waits");
   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> busy)
      else $error("response pending while back end idle");

endmodule
`default_nettype wire

FILE: verif/x86_integer_alu_flags_core_test.sv
`timescale 1ns / 100ps
`default_nettype none
module x86_integer_alu_flags_core_test;

   localparam logic [3:0] OP_SPARE_LO = 4'd14;
   localparam logic [3:0] OP_SPARE_HI = 4'd15;
   localparam int RandomWords = 1500;
   localparam int StallLimit  = 5000;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [175:0]  req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [103:0]  rsp_tdata;

   x86_integer_alu_flags_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // flag state of the predictor
   logic cf_q, of_q, zf_q, sf_q;
   xalu_pkg::rsp_type pending_rsp[$];
   int errors;
   int idle_cycles;
   logic feeding_done;

   typedef struct {
      logic [3:0]  opcode;
      logic [2:0]  ow;
      logic [2:0]  sw;
      logic [31:0] dv;
      logic [31:0] sv;
      logic [31:0] s2;
      logic [31:0] ea;
      logic [31:0] ed;
      logic        typed;
      xalu_pkg::rsp_type want;
   } stim_row;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int bits_of(input logic [2:0] w);
      int b;
      b = (w == 3'd1) ? 8 : (w == 3'd2) ? 16 : 32;
      return b;
   endfunction

   function automatic logic [63:0] lmask(input int bits);
      logic [63:0] m;
      m = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
      return m;
   endfunction

   function automatic logic [63:0] sx64(input logic [63:0] v, input int bits);
      logic [63:0] m;
      logic [63:0] r;
      m = lmask(bits);
      r = v & m;
      if (r[bits-1]) r = r | ~m;
      return r;
   endfunction

   function automatic logic [175:0] pack_req(input stim_row r);
      logic [175:0] w;
      w = '0;
      w[3:0] = r.opcode;
      w[6:4] = r.ow;
      w[9:7] = r.sw;
      w[41:10] = r.dv;
      w[73:42] = r.sv;
      w[105:74] = r.s2;
      w[137:106] = r.ea;
      w[169:138] = r.ed;
      return w;
   endfunction

   function automatic xalu_pkg::rsp_type unpack_rsp(input logic [103:0] w);
      xalu_pkg::rsp_type o;
      o.result = w[31:0];
      o.write_dest = w[32];
      o.acc_low = w[64:33];
      o.acc_high = w[96:65];
      o.acc_write_mode = w[98:97];
      o.carry_flag = w[99];
      o.overflow_flag = w[100];
      o.zero_flag = w[101];
      o.sign_flag = w[102];
      o.divide_error = w[103];
      return o;
   endfunction

   // executes one word against the flag state, updating it
   function automatic xalu_pkg::rsp_type alu_predict(input stim_row r);
      xalu_pkg::rsp_type o;
      int wb, sb, nb;
      logic [63:0] m, smask, sgn, d, s, c, t, res, lo, hi, p, n, q, rem;
      logic [63:0] nmag, dmag, qm, rm;
      logic [1:0] mode;
      logic wr, de, mulform, ns, ds, ng;
      wb = bits_of(r.ow);
      sb = bits_of(r.sw);
      m = lmask(wb);
      smask = lmask(sb);
      sgn = 64'd1 << (wb - 1);
      d = {32'd0, r.dv} & m;
      s = {32'd0, r.sv} & m;
      c = cf_q ? 64'd1 : 64'd0;
      res = 0; lo = 0; hi = 0; p = 0; mode = xalu_pkg::ACC_NONE;
      wr = 0; de = 0; mulform = 0;
      case (r.opcode)
         xalu_pkg::OP_ADD, xalu_pkg::OP_ADC: begin
            if (r.opcode == xalu_pkg::OP_ADD) c = 0;
            t = d + s + c;
            res = t & m;
            wr = 1;
            cf_q = t > m;
            of_q = ((~(d ^ s)) & (d ^ res) & sgn) != 0;
            zf_q = res == 0;
            sf_q = (res & sgn) != 0;
         end
         xalu_pkg::OP_SUB, xalu_pkg::OP_CMP, xalu_pkg::OP_SBB: begin
            if (r.opcode != xalu_pkg::OP_SBB) c = 0;
            t = (d - s - c) & m;
            cf_q = d < s + c;
            of_q = ((d ^ s) & (d ^ t) & sgn) != 0;
            zf_q = t == 0;
            sf_q = (t & sgn) != 0;
            if (r.opcode != xalu_pkg::OP_CMP) begin
               res = t;
               wr = 1;
            end
         end
         xalu_pkg::OP_INC, xalu_pkg::OP_DEC, xalu_pkg::OP_NEG: begin
            if (r.opcode == xalu_pkg::OP_INC) begin
               res = (d + 1) & m;
               of_q = res == sgn;
            end else if (r.opcode == xalu_pkg::OP_DEC) begin
               res = (d - 1) & m;
               of_q = d == sgn;
            end else begin
               res = (64'd0 - d) & m;
               of_q = d == sgn;
               cf_q = d != 0;
            end
            wr = 1;
            zf_q = res == 0;
            sf_q = (res & sgn) != 0;
         end
         xalu_pkg::OP_MUL: begin
            p = d * ({32'd0, r.ea} & m);
            mulform = 1;
         end
         xalu_pkg::OP_IMUL1: begin
            p = sx64(d, wb) * sx64({32'd0, r.ea} & m, wb);
            mulform = 1;
         end
         xalu_pkg::OP_IMUL2: begin
            res = (sx64(d, wb) * sx64({32'd0, r.sv} & smask, sb)) & m;
            wr = 1;
         end
         xalu_pkg::OP_IMUL3: begin
            res = (sx64({32'd0, r.sv} & smask, sb) * sx64({32'd0, r.s2} & smask, sb)) & m;
            wr = 1;
         end
         xalu_pkg::OP_DIV, xalu_pkg::OP_IDIV: begin
            nb = 2 * wb;
            if (wb == 8) n = {48'd0, r.ea[15:0]};
            else if (wb == 16) n = {32'd0, r.ed[15:0], r.ea[15:0]};
            else n = {r.ed, r.ea};
            if (r.opcode == xalu_pkg::OP_DIV) begin
               if (d == 0) de = 1;
               else begin
                  q = n / d;
                  rem = n % d;
                  if (q > m) de = 1;
               end
            end else begin
               ns = n[nb-1];
               ds = (d & sgn) != 0;
               nmag = ns ? ((64'd0 - n) & lmask(nb)) : n;
               dmag = ds ? ((64'd0 - d) & m) : d;
               ng = ns != ds;
               if (dmag == 0) de = 1;
               else begin
                  qm = nmag / dmag;
                  rm = nmag % dmag;
                  if (qm > (ng ? sgn : sgn - 1)) de = 1;
                  q = (ng ? 64'd0 - qm : qm) & m;
                  rem = (ns ? 64'd0 - rm : rm) & m;
               end
            end
            if (!de) begin
               if (wb == 8) begin
                  lo = {48'd0, rem[7:0], q[7:0]};
                  mode = xalu_pkg::ACC_AX;
               end else begin
                  lo = q;
                  hi = rem;
                  mode = (wb == 16) ? xalu_pkg::ACC_AXDX : xalu_pkg::ACC_EAXDX;
               end
            end
         end
         default: ;
      endcase
      if (mulform) begin
         if (wb == 8) begin
            lo = p & 64'hffff;
            mode = xalu_pkg::ACC_AX;
         end else if (wb == 16) begin
            lo = p & 64'hffff;
            hi = (p >> 16) & 64'hffff;
            mode = xalu_pkg::ACC_AXDX;
         end else begin
            lo = p[31:0];
            hi = p[63:32];
            mode = xalu_pkg::ACC_EAXDX;
         end
      end
      o.result = wr ? res[31:0] : 32'd0;
      o.write_dest = wr;
      o.acc_low = lo[31:0];
      o.acc_high = hi[31:0];
      o.acc_write_mode = mode;
      o.carry_flag = cf_q;
      o.overflow_flag = of_q;
      o.zero_flag = zf_q;
      o.sign_flag = sf_q;
      o.divide_error = de;
      return o;
   endfunction

   function automatic xalu_pkg::rsp_type mk_rsp(input logic [31:0] res, input logic wr,
                                                input logic cf, input logic ovf,
                                                input logic zf, input logic sf,
                                                input logic de);
      xalu_pkg::rsp_type o;
      o = '0;
      o.result = res;
      o.write_dest = wr;
      o.carry_flag = cf;
      o.overflow_flag = ovf;
      o.zero_flag = zf;
      o.sign_flag = sf;
      o.divide_error = de;
      return o;
   endfunction

   function automatic logic [31:0] edge_val();
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0: v = 32'd0;
         1: v = 32'hffff_ffff;
         2: v = 32'h8000_0000;
         3: v = 32'h7fff_ffff;
         4: v = 32'h0000_0080 << (8 * $urandom_range(0, 1));
         5: v = 32'd1;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic logic [2:0] rand_width();
      logic [2:0] w;
      case ($urandom_range(0, 9))
         0, 1, 2: w = 3'd1;
         3, 4, 5: w = 3'd2;
         6, 7, 8: w = 3'd4;
         default: w = 3'($urandom_range(0, 7));
      endcase
      return w;
   endfunction

   function automatic stim_row rand_row();
      stim_row r;
      logic [31:0] dm;
      r.opcode = ($urandom_range(0, 39) == 0) ? 4'($urandom_range(14, 15))
                                               : 4'($urandom_range(0, 13));
      r.ow = rand_width();
      r.sw = rand_width();
      r.dv = edge_val();
      r.sv = edge_val();
      r.s2 = edge_val();
      r.ea = edge_val();
      r.ed = edge_val();
      r.typed = 1'b0;
      r.want = '0;
      // keep most divides in range so quotients get exercised
      if ((r.opcode == xalu_pkg::OP_DIV || r.opcode == xalu_pkg::OP_IDIV) &&
          $urandom_range(0, 3) != 0) begin
         dm = 32'(lmask(bits_of(r.ow)));
         if (r.dv == 0) r.dv = $urandom | 32'd1;
         if (r.opcode == xalu_pkg::OP_DIV) begin
            r.ed = $urandom % ((r.dv & dm) >> 1 | 32'd1);
            if (bits_of(r.ow) == 8) r.ea[15:8] = r.ed[7:0];
         end else begin
            r.ed = r.ea[31] ? '1 : '0;
            if (bits_of(r.ow) == 8) r.ea[15:8] = {8{r.ea[7]}};
         end
      end
      return r;
   endfunction

   // stimulus sender
   task automatic send_word(input stim_row r, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= pack_req(r);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (r.typed) begin
         void'(alu_predict(r));
         pending_rsp.push_back(r.want);
      end else begin
         pending_rsp.push_back(alu_predict(r));
      end
      @(negedge clock);
   endtask

   stim_row directed[$];

   task automatic add_row(input logic [3:0] op, input logic [2:0] ow, input logic [2:0] sw,
                          input logic [31:0] dv, input logic [31:0] sv, input logic [31:0] s2,
                          input logic [31:0] ea, input logic [31:0] ed);
      stim_row r;
      r.opcode = op; r.ow = ow; r.sw = sw; r.dv = dv; r.sv = sv; r.s2 = s2;
      r.ea = ea; r.ed = ed; r.typed = 1'b0; r.want = '0;
      directed.push_back(r);
   endtask

   initial begin
      stim_row r;
      logic burst;
      int gap;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      feeding_done = 1'b0;
      cf_q = 0; of_q = 0; zf_q = 0; sf_q = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // typed rows: read straight off the flag rules
      add_row(xalu_pkg::OP_ADD, 3'd4, 3'd4, 0, 0, 0, 0, 0);
      directed[$].typed = 1'b1;
      directed[$].want = mk_rsp(0, 1, 0, 0, 1, 0, 0);
      add_row(xalu_pkg::OP_DIV, 3'd1, 3'd1, 0, 0, 0, 32'h1234, 0);
      directed[$].typed = 1'b1;
      directed[$].want = mk_rsp(0, 0, 0, 0, 1, 0, 1);
      add_row(xalu_pkg::OP_ADD, 3'd1, 3'd1, 32'hff, 32'h01, 0, 0, 0);
      directed[$].typed = 1'b1;
      directed[$].want = mk_rsp(0, 1, 1, 0, 1, 0, 0);
      add_row(xalu_pkg::OP_ADC, 3'd2, 3'd2, 32'h7fff, 32'h0, 0, 0, 0);
      add_row(xalu_pkg::OP_SUB, 3'd4, 3'd4, 32'h8000_0000, 32'h1, 0, 0, 0);
      add_row(xalu_pkg::OP_SBB, 3'd4, 3'd4, 32'h0, 32'hffff_ffff, 0, 0, 0);
      add_row(xalu_pkg::OP_SBB, 3'd1, 3'd1, 32'h0, 32'hff, 0, 0, 0);
      add_row(xalu_pkg::OP_CMP, 3'd2, 3'd2, 32'h1234, 32'h1234, 0, 0, 0);
      add_row(xalu_pkg::OP_INC, 3'd1, 3'd1, 32'h7f, 0, 0, 0, 0);
      add_row(xalu_pkg::OP_DEC, 3'd2, 3'd2, 32'h8000, 0, 0, 0, 0);
      add_row(xalu_pkg::OP_NEG, 3'd4, 3'd4, 32'h8000_0000, 0, 0, 0, 0);
      add_row(xalu_pkg::OP_NEG, 3'd1, 3'd1, 32'h0, 0, 0, 0, 0);
      add_row(xalu_pkg::OP_MUL, 3'd4, 3'd4, 32'hffff_ffff, 0, 0, 32'hffff_ffff, 0);
      add_row(xalu_pkg::OP_MUL, 3'd1, 3'd1, 32'hff, 0, 0, 32'hff, 0);
      add_row(xalu_pkg::OP_IMUL1, 3'd2, 3'd2, 32'h8000, 0, 0, 32'h8000, 0);
      add_row(xalu_pkg::OP_IMUL1, 3'd4, 3'd4, 32'hffff_ffff, 0, 0, 32'h8000_0000, 0);
      add_row(xalu_pkg::OP_IMUL2, 3'd4, 3'd1, 32'hffff_fffe, 32'h80, 0, 0, 0);
      add_row(xalu_pkg::OP_IMUL3, 3'd2, 3'd2, 0, 32'hffff, 32'h7fff, 0, 0);
      add_row(xalu_pkg::OP_DIV, 3'd4, 3'd4, 32'hffff_ffff, 0, 0, 32'hffff_ffff,
              32'hffff_fffe);
      add_row(xalu_pkg::OP_DIV, 3'd2, 3'd2, 32'h1, 0, 0, 32'h0, 32'h1);
      add_row(xalu_pkg::OP_IDIV, 3'd1, 3'd1, 32'hff, 0, 0, 32'hff80, 0);
      add_row(xalu_pkg::OP_IDIV, 3'd4, 3'd4, 32'hffff_fff9, 0, 0, 32'hffff_ffe5,
              32'hffff_ffff);
      add_row(xalu_pkg::OP_IDIV, 3'd2, 3'd2, 32'h0, 0, 0, 32'h1, 0);
      add_row(xalu_pkg::OP_ADD, 3'd3, 3'd0, 32'hffff_ffff, 32'h1, 0, 0, 0);
      add_row(OP_SPARE_LO, 3'd7, 3'd5, '1, '1, '1, '1, '1);
      add_row(OP_SPARE_HI, 3'd0, 3'd6, 0, 0, 0, 0, 0);

      foreach (directed[i]) send_word(directed[i], $urandom_range(0, 5));

      burst = 1'b0;
      for (int k = 0; k < RandomWords; k++) begin
         if ($urandom_range(0, 49) == 0) burst = ~burst;
         if (k == RandomWords / 2) begin
            // drain before carrying on
            req_tvalid <= 1'b0;
            wait (pending_rsp.size() == 0);
            @(negedge clock);
         end
         gap = burst ? 0 : $urandom_range(0, 5);
         r = rand_row();
         send_word(r, gap);
      end
      req_tvalid <= 1'b0;
      feeding_done = 1'b1;
   end

   // receiver back-pressure
   initial begin
      int stall;
      logic burst;
      rsp_tready = 1'b0;
      burst = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0) burst = ~burst;
         stall = burst ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // response check and watchdog
   always @(posedge clock) begin
      xalu_pkg::rsp_type got, want;
      if (reset) begin
         errors <= 0;
         idle_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got = unpack_rsp(rsp_tdata);
            if (pending_rsp.size() == 0) begin
               if (errors < 10) $display("unexpected word %h", rsp_tdata);
               errors <= errors + 1;
            end else begin
               want = pending_rsp.pop_front();
               if (got !== want) begin
                  if (errors < 10)
                     $display("word mismatch: expected %p got %p", want, got);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

   initial begin
      wait (feeding_done === 1'b1 && pending_rsp.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("x86_integer_alu_flags_core: match");
      end else begin
         $display("x86_integer_alu_flags_core: mismatch");
      end
      $finish;
   end

   initial begin
      wait (idle_cycles >= StallLimit);
      $display("x86_integer_alu_flags_core: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
